### design/ldrt_pkg.sv
// ----------------------------------------------------------------------------
// ldrt_pkg
// Shared types, sizes and helpers for the longest distinct run tracker.
// ----------------------------------------------------------------------------
package ldrt_pkg;

  localparam int ALPHABET_SIZE = 128;
  localparam int ADDR_BITS     = $clog2(ALPHABET_SIZE);
  localparam int POS_BITS      = 16;
  localparam int CODE_BITS     = 7;
  localparam int LEN_OUT_BITS  = 16;

  localparam logic [POS_BITS-1:0]     POS_MAX = {POS_BITS{1'b1}};
  localparam logic [LEN_OUT_BITS-1:0] OUT_MAX = {LEN_OUT_BITS{1'b1}};

  typedef struct packed {
    logic [CODE_BITS-1:0] char_code;
    logic                 final_char;
  } in_t;

  typedef struct packed {
    logic [LEN_OUT_BITS-1:0] window_length;
    logic [LEN_OUT_BITS-1:0] best_length;
    logic                    string_end;
    logic                    length_overflow;
  } out_t;

  // Saturate a position-wide length to the output width.
  function automatic logic [LEN_OUT_BITS-1:0] clamp_len(input logic [POS_BITS-1:0] v);
    logic [32:0] w;
    w = 33'(v);
    if (w > 33'(OUT_MAX)) begin
      return OUT_MAX;
    end
    return LEN_OUT_BITS'(w);
  endfunction

  // Fold a character code into the table index range.
  function automatic logic [ADDR_BITS-1:0] code_index(input logic [CODE_BITS-1:0] c);
    return ADDR_BITS'(32'(c) % ALPHABET_SIZE);
  endfunction

endpackage

### design/longest_distinct_run_tracker_unit.sv
// ----------------------------------------------------------------------------
// longest_distinct_run_tracker_unit
// Streams characters and reports the current and longest distinct run.
// ----------------------------------------------------------------------------
// Takes one character per cycle unless the output stalls, and returns one
// result per character through the stage 1 and output registers. The last-seen
// position of each code lives in a 128-entry RAM with one write and one
// registered read port; the read is issued when a character is accepted and
// the write happens as it leaves stage 1, with a bypass for a character that
// repeats the one just before it. Seen flags sit in flip-flops and clear at
// once on the final character of a string, so the next string may follow
// immediately. An output register holds a result while downstream stalls.
module longest_distinct_run_tracker_unit
  import ldrt_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);

  // Stage 1: item waiting for its table read data
  logic                 s1_valid;
  logic [ADDR_BITS-1:0] s1_idx;
  logic                 s1_final;
  logic                 s1_fwd_hit;
  logic [POS_BITS-1:0]  s1_fwd_pos;

  logic [ALPHABET_SIZE-1:0] seen;
  logic [POS_BITS-1:0]      window_start;
  logic [POS_BITS-1:0]      char_position;
  logic [POS_BITS-1:0]      longest_so_far;
  logic                     overflow_seen;

  logic                 in_fire;
  logic                 s1_fire;
  logic                 advance;
  logic [ADDR_BITS-1:0] rd_idx;
  logic [POS_BITS-1:0]  rd_pos;
  logic [POS_BITS-1:0]  prev_pos;
  logic                 ovf_now;
  logic                 repeat_hit;
  logic [POS_BITS-1:0]  window_start_next;
  logic [POS_BITS-1:0]  win_len;
  logic [POS_BITS-1:0]  longest_next;
  logic                 wr_en;

  assign advance  = !out_valid || out_ready;
  assign s1_fire  = s1_valid && advance;
  assign in_ready = !s1_valid || advance;
  assign in_fire  = in_valid && in_ready;
  assign rd_idx   = code_index(in_data.char_code);

  ldrt_ram #(
    .WIDTH(POS_BITS),
    .DEPTH(ALPHABET_SIZE)
  ) u_pos_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (s1_idx),
    .wr_data (char_position),
    .rd_en   (in_fire),
    .rd_addr (rd_idx),
    .rd_data (rd_pos)
  );

  always_comb begin
    prev_pos   = s1_fwd_hit ? s1_fwd_pos : rd_pos;
    ovf_now    = overflow_seen || (char_position == POS_MAX);
    repeat_hit = seen[s1_idx] && (prev_pos >= window_start);
    window_start_next = repeat_hit ? prev_pos + POS_BITS'(1) : window_start;
    if (ovf_now) begin
      win_len      = POS_MAX;
      longest_next = POS_MAX;
    end else begin
      win_len      = char_position - window_start_next + POS_BITS'(1);
      longest_next = (win_len > longest_so_far) ? win_len : longest_so_far;
    end
    wr_en = s1_fire && !ovf_now;
  end

  // Stage 1 capture; bypass a write that lands in the same cycle as the read
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_fire) begin
      s1_valid <= 1'b1;
    end else if (s1_fire) begin
      s1_valid <= 1'b0;
    end
    if (in_fire) begin
      s1_idx     <= rd_idx;
      s1_final   <= in_data.final_char;
      s1_fwd_hit <= wr_en && (s1_idx == rd_idx);
      s1_fwd_pos <= char_position;
    end
  end

  // String state
  always_ff @(posedge clk) begin
    if (rst) begin
      seen           <= '0;
      window_start   <= '0;
      char_position  <= '0;
      longest_so_far <= '0;
      overflow_seen  <= 1'b0;
    end else if (s1_fire) begin
      if (s1_final) begin
        seen           <= '0;
        window_start   <= '0;
        char_position  <= '0;
        longest_so_far <= '0;
        overflow_seen  <= 1'b0;
      end else begin
        overflow_seen  <= ovf_now;
        longest_so_far <= longest_next;
        if (!ovf_now) begin
          seen[s1_idx]  <= 1'b1;
          window_start  <= window_start_next;
          char_position <= char_position + POS_BITS'(1);
        end
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (s1_fire) begin
      out_data.window_length   <= clamp_len(win_len);
      out_data.best_length     <= clamp_len(longest_next);
      out_data.string_end      <= s1_final;
      out_data.length_overflow <= ovf_now;
    end
  end

endmodule

### design/ldrt_ram.sv
// ----------------------------------------------------------------------------
// ldrt_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ldrt_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### tb/sv/longest_distinct_run_tracker_unit_tb.sv
// ----------------------------------------------------------------------------
// longest_distinct_run_tracker_unit_tb
// Self-checking bench for the longest distinct run tracker.
// ----------------------------------------------------------------------------
// A short table of directed strings comes first: code extremes, back-to-back
// repeats, a repeat whose old occurrence lies before the window, and
// one-character strings. Random strings follow, with small and full
// alphabets, under several sender and receiver idling mixes. One phase blocks
// the receiver for a long stretch so that the unit backs up. Every result
// is checked against typed row values or a behavioral tracker run per character.
// ----------------------------------------------------------------------------
module longest_distinct_run_tracker_unit_tb;
  import ldrt_pkg::*;

  localparam int CYCLE_LIMIT  = 500000;
  localparam int HOLD_CYCLES  = 400;

  typedef struct packed {
    in_t  d;
    logic typed;  // use want instead of the tracker's prediction
    out_t want;
  } char_req_t;

  localparam out_t NO_WANT = '0;

  localparam int N_DIRECTED = 24;
  localparam char_req_t DIRECTED_ROWS [N_DIRECTED] = '{
    '{'{7'd0,   1'b0}, 1'b1, '{16'd1, 16'd1, 1'b0, 1'b0}},
    '{'{7'd127, 1'b0}, 1'b1, '{16'd2, 16'd2, 1'b0, 1'b0}},
    '{'{7'd0,   1'b0}, 1'b0, NO_WANT},
    '{'{7'd0,   1'b0}, 1'b0, NO_WANT},
    '{'{7'd127, 1'b1}, 1'b0, NO_WANT},
    '{'{7'd127, 1'b1}, 1'b1, '{16'd1, 16'd1, 1'b1, 1'b0}},
    '{'{7'd97,  1'b0}, 1'b1, '{16'd1, 16'd1, 1'b0, 1'b0}},
    '{'{7'd98,  1'b0}, 1'b0, NO_WANT},
    '{'{7'd98,  1'b0}, 1'b0, NO_WANT},
    '{'{7'd97,  1'b1}, 1'b0, NO_WANT},
    '{'{7'd97,  1'b0}, 1'b0, NO_WANT},
    '{'{7'd98,  1'b0}, 1'b0, NO_WANT},
    '{'{7'd99,  1'b0}, 1'b0, NO_WANT},
    '{'{7'd97,  1'b0}, 1'b0, NO_WANT},
    '{'{7'd98,  1'b0}, 1'b0, NO_WANT},
    '{'{7'd99,  1'b0}, 1'b0, NO_WANT},
    '{'{7'd98,  1'b0}, 1'b0, NO_WANT},
    '{'{7'd98,  1'b1}, 1'b0, NO_WANT},
    '{'{7'd85,  1'b0}, 1'b0, NO_WANT},
    '{'{7'd42,  1'b0}, 1'b0, NO_WANT},
    '{'{7'd85,  1'b0}, 1'b0, NO_WANT},
    '{'{7'd42,  1'b0}, 1'b0, NO_WANT},
    '{'{7'd85,  1'b1}, 1'b0, NO_WANT},
    '{'{7'd0,   1'b1}, 1'b1, '{16'd1, 16'd1, 1'b1, 1'b0}}
  };

  logic clk       = 1'b0;
  logic rst       = 1'b1;
  logic in_valid  = 1'b0;
  logic in_ready;
  in_t  in_data   = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;

  longest_distinct_run_tracker_unit u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always #10 clk = ~clk;

  // Tracker state
  bit          seen_flag [ALPHABET_SIZE];
  int unsigned seen_pos  [ALPHABET_SIZE];
  int unsigned win_start;
  int unsigned next_pos;
  int unsigned best_len;
  bit          sat_flag;

  char_req_t   stim_q [$];
  out_t        pending_results [$];
  char_req_t   cur_req;
  out_t        predicted;
  out_t        want_res;
  int          snd_idle_pct  = 0;
  int          rcv_stall_pct = 0;
  bit          hold_off      = 1'b0;
  int          err_cnt       = 0;
  int          cycle_cnt     = 0;

  function automatic void clear_tracker();
    for (int i = 0; i < ALPHABET_SIZE; i++) begin
      seen_flag[i] = 1'b0;
      seen_pos[i]  = 0;
    end
    win_start = 0;
    next_pos  = 0;
    best_len  = 0;
    sat_flag  = 1'b0;
  endfunction

  function automatic out_t track_char(input in_t c);
    out_t                 r;
    logic [ADDR_BITS-1:0] ix;
    int unsigned          run;
    ix = ADDR_BITS'(int'(c.char_code) % ALPHABET_SIZE);
    if (!sat_flag && next_pos >= int'(POS_MAX)) sat_flag = 1'b1;
    if (sat_flag) begin
      run      = 32'(POS_MAX);
      best_len = 32'(POS_MAX);
    end else begin
      // jump the window past an earlier copy still inside it
      if (seen_flag[ix] && seen_pos[ix] >= win_start) win_start = seen_pos[ix] + 1;
      seen_flag[ix] = 1'b1;
      seen_pos[ix]  = next_pos;
      run = next_pos - win_start + 1;
      if (run > best_len) best_len = run;
      next_pos++;
    end
    r.window_length   = (run > OUT_MAX) ? OUT_MAX : LEN_OUT_BITS'(run);
    r.best_length     = (best_len > OUT_MAX) ? OUT_MAX : LEN_OUT_BITS'(best_len);
    r.string_end      = c.final_char;
    r.length_overflow = sat_flag;
    if (c.final_char) clear_tracker();
    return r;
  endfunction

  // Sender: predict on each accepted transaction, then offer the next one
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        predicted = track_char(in_data);
        pending_results.push_back(cur_req.typed ? cur_req.want : predicted);
      end
      if (!in_valid || in_ready) begin
        if (stim_q.size() != 0 && $urandom_range(99) >= snd_idle_pct) begin
          cur_req = stim_q.pop_front();
          in_valid <= 1'b1;
          in_data  <= cur_req.d;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: check each result transaction against the oldest expected result
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          err_cnt++;
          if (err_cnt <= 10) $display("unexpected result: %p", out_data);
        end else begin
          want_res = pending_results.pop_front();
          if (out_data.window_length !== want_res.window_length ||
              out_data.best_length !== want_res.best_length ||
              out_data.string_end !== want_res.string_end ||
              out_data.length_overflow !== want_res.length_overflow) begin
            err_cnt++;
            if (err_cnt <= 10)
              $display({"mismatch: expected win=%0d best=%0d end=%0d ovf=%0d,",
                        " got win=%0d best=%0d end=%0d ovf=%0d"},
                       want_res.window_length, want_res.best_length,
                       want_res.string_end, want_res.length_overflow,
                       out_data.window_length, out_data.best_length,
                       out_data.string_end, out_data.length_overflow);
          end
        end
      end
      out_ready <= !hold_off && ($urandom_range(99) >= rcv_stall_pct);
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Random strings, mostly short, over alphabets from two codes to all of them
  task automatic queue_strings(input int n_items);
    int                   left;
    int                   len;
    int                   span;
    logic [CODE_BITS-1:0] base;
    char_req_t            r;
    left = n_items;
    while (left > 0) begin
      len = ($urandom_range(7) == 0) ? $urandom_range(25, 300) : $urandom_range(1, 24);
      if (len > left) len = left;
      case ($urandom_range(3))
        0:       span = 2;
        1:       span = 8;
        2:       span = 32;
        default: span = ALPHABET_SIZE;
      endcase
      base = CODE_BITS'($urandom);
      for (int i = 0; i < len; i++) begin
        r = '0;
        r.d.char_code  = base + CODE_BITS'($urandom_range(span - 1));
        r.d.final_char = (i == len - 1);
        stim_q.push_back(r);
      end
      left -= len;
    end
  endtask

  // Sample at the falling edge so the check never races the clocked processes
  task automatic drain();
    while (stim_q.size() != 0 || in_valid || pending_results.size() != 0) @(negedge clk);
  endtask

  task automatic run_phase(input int snd_pct, input int rcv_pct, input int n_items);
    @(negedge clk);
    snd_idle_pct  = snd_pct;
    rcv_stall_pct = rcv_pct;
    queue_strings(n_items);
    drain();
  endtask

  initial begin
    clear_tracker();
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    @(negedge clk);
    for (int i = 0; i < N_DIRECTED; i++) stim_q.push_back(DIRECTED_ROWS[i]);
    drain();

    run_phase(0, 0, 300);
    run_phase(57, 0, 300);
    run_phase(0, 57, 300);
    run_phase(33, 33, 300);

    // block the receiver while the sender keeps offering, so the unit backs up
    @(negedge clk);
    snd_idle_pct  = 0;
    rcv_stall_pct = 0;
    fork
      begin
        hold_off = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_off = 1'b0;
      end
    join_none
    queue_strings(150);
    drain();

    run_phase(20, 20, 60);

    repeat (10) @(posedge clk);
    if (err_cnt == 0 && pending_results.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

### sim.f
design/ldrt_pkg.sv
design/ldrt_ram.sv
design/longest_distinct_run_tracker_unit.sv
tb/sv/longest_distinct_run_tracker_unit_tb.sv
